FILE: rtl/abc_pkg.sv
// ----------------------------------------------------------------------------
// abc_pkg
// Shared types and constants for the audio bit crusher.
// ----------------------------------------------------------------------------
`default_nettype none

package abc_pkg;

    localparam int GAIN_BITS   = 24;
    localparam int GAIN_CNT_W  = $clog2(GAIN_BITS);
    localparam int DEPTH_W     = 5;
    localparam int DEPTH_MAX   = 16;
    localparam int HOLD_W      = 8;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DRIVE_GAIN  = 2'd0,
        CFG_DEPTH_BITS  = 2'd1,
        CFG_HOLD_FACTOR = 2'd2,
        CFG_OUT_GAIN    = 2'd3
    } cfg_index_t;

    typedef logic [GAIN_BITS-1:0] gain_t;
    typedef logic [DEPTH_W-1:0]   depth_t;
    typedef logic [HOLD_W-1:0]    hold_t;

endpackage

`default_nettype wire

FILE: rtl/abc_gain_mul.sv
// ----------------------------------------------------------------------------
// abc_gain_mul
// Bit-serial signed-by-unsigned gain multiplier, one gain bit per cycle,
// with floor shift and saturation to full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_gain_mul #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic signed [SAMPLE_BITS-1:0] x,
    input  wire abc_pkg::gain_t                gain,
    output logic                               done,
    output logic signed [SAMPLE_BITS-1:0]      result
);

    localparam int PROD_W = SAMPLE_BITS + abc_pkg::GAIN_BITS;
    localparam int SHR_W  = PROD_W - GAIN_FRAC_BITS;
    localparam int CW     = abc_pkg::GAIN_CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(abc_pkg::GAIN_BITS - 1);

    logic [SAMPLE_BITS-1:0]          x_reg;
    logic [SAMPLE_BITS-1:0]          acc_reg, acc_next;
    abc_pkg::gain_t                  lo_reg, lo_next;
    abc_pkg::gain_t                  g_reg;
    logic [CW-1:0]                   cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [SAMPLE_BITS:0]            addend;
    logic [SAMPLE_BITS:0]            sum;
    logic [PROD_W-1:0]               prod;
    logic [SHR_W-1:0]                shifted;
    logic [SHR_W-SAMPLE_BITS:0]      upper;

    always_comb begin
        addend   = g_reg[0] ? {x_reg[SAMPLE_BITS-1], x_reg} : '0;
        sum      = {acc_reg[SAMPLE_BITS-1], acc_reg} + addend;
        acc_next = sum[SAMPLE_BITS:1];
        lo_next  = {sum[0], lo_reg[abc_pkg::GAIN_BITS-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= x;
            g_reg    <= gain;
            acc_reg  <= '0;
            lo_reg   <= '0;
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            lo_reg   <= lo_next;
            g_reg    <= g_reg >> 1;
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_comb begin
        prod    = {acc_reg, lo_reg};
        shifted = prod[PROD_W-1:GAIN_FRAC_BITS];
        upper   = shifted[SHR_W-1:SAMPLE_BITS-1];
        if (upper == '0 || upper == '1) begin
            result = signed'(shifted[SAMPLE_BITS-1:0]);
        end else if (shifted[SHR_W-1]) begin
            result = signed'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        end else begin
            result = signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/audio_bit_crusher_unit.sv
// ----------------------------------------------------------------------------
// audio_bit_crusher_unit
// Bit crusher with sample-and-hold downsampling: drive gain, clip, floor to
// the configured depth, output gain, saturate.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. A held (repeated) sample is accepted and
// appears on the result register at the next edge. A computed sample passes
// through the single bit-serial gain multiplier, which retires one gain bit per
// cycle and is used twice, once for the drive gain and once for the output
// gain, in 24 steps plus a turnaround each. The next sample is taken once the
// result register is free or being drained in the same cycle. Configuration
// writes are taken in every cycle and must only be issued while the block is
// idle.
`default_nettype none

module audio_bit_crusher_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [abc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [abc_pkg::GAIN_BITS-1:0]        cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]        s_sample_in,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]             m_sample_out
);

    localparam abc_pkg::gain_t UNITY_GAIN = abc_pkg::gain_t'(1) << GAIN_FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_OUTG
    } state_t;

    state_t                        state_reg;
    abc_pkg::gain_t                drive_gain_reg;
    abc_pkg::depth_t               depth_bits_reg;
    abc_pkg::hold_t                hold_factor_reg;
    abc_pkg::gain_t                out_gain_reg;
    abc_pkg::hold_t                hold_count_reg;
    logic [SAMPLE_BITS-1:0]        held_reg;
    logic                          m_valid_reg;
    logic [SAMPLE_BITS-1:0]        m_sample_reg;

    logic                          s_xfer;
    abc_pkg::hold_t                hold_count_next;
    logic                          hold_hit;
    abc_pkg::depth_t               depth_eff;
    logic signed [SAMPLE_BITS-1:0] quant;
    logic                          mul_start;
    logic signed [SAMPLE_BITS-1:0] mul_x;
    abc_pkg::gain_t                mul_gain;
    logic                          mul_done;
    logic signed [SAMPLE_BITS-1:0] mul_result;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_xfer       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = signed'(m_sample_reg);

    assign hold_count_next = hold_count_reg + 1'b1;
    assign hold_hit        = hold_count_next < hold_factor_reg;

    always_comb begin
        if (depth_bits_reg == '0) begin
            depth_eff = abc_pkg::depth_t'(1);
        end else if (depth_bits_reg > abc_pkg::depth_t'(abc_pkg::DEPTH_MAX)) begin
            depth_eff = abc_pkg::depth_t'(abc_pkg::DEPTH_MAX);
        end else begin
            depth_eff = depth_bits_reg;
        end
        for (int j = 0; j < SAMPLE_BITS; j++) begin
            quant[j] = (int'(depth_eff) + j >= SAMPLE_BITS) ? mul_result[j] : 1'b0;
        end
    end

    always_comb begin
        mul_start = (s_xfer && !hold_hit) || (state_reg == ST_DRIVE && mul_done);
        mul_x     = (state_reg == ST_DRIVE) ? quant : s_sample_in;
        mul_gain  = (state_reg == ST_DRIVE) ? out_gain_reg : drive_gain_reg;
    end

    abc_gain_mul #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .gain    (mul_gain),
        .done    (mul_done),
        .result  (mul_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_gain_reg  <= UNITY_GAIN;
            depth_bits_reg  <= abc_pkg::depth_t'(abc_pkg::DEPTH_MAX);
            hold_factor_reg <= '0;
            out_gain_reg    <= UNITY_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            case (abc_pkg::cfg_index_t'(cfg_index))
                abc_pkg::CFG_DRIVE_GAIN:  drive_gain_reg  <= cfg_data;
                abc_pkg::CFG_DEPTH_BITS:  depth_bits_reg  <= cfg_data[abc_pkg::DEPTH_W-1:0];
                abc_pkg::CFG_HOLD_FACTOR: hold_factor_reg <= cfg_data[abc_pkg::HOLD_W-1:0];
                abc_pkg::CFG_OUT_GAIN:    out_gain_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hold_count_reg <= '0;
            held_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !(s_xfer && hold_hit)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        if (hold_hit) begin
                            hold_count_reg <= hold_count_next;
                            m_sample_reg   <= held_reg;
                            m_valid_reg    <= 1'b1;
                        end else begin
                            hold_count_reg <= '0;
                            state_reg      <= ST_DRIVE;
                        end
                    end
                end
                ST_DRIVE: begin
                    if (mul_done) begin
                        state_reg <= ST_OUTG;
                    end
                end
                ST_OUTG: begin
                    if (mul_done) begin
                        held_reg     <= mul_result;
                        m_sample_reg <= mul_result;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/audio_bit_crusher_unit_checker.sv
// ----------------------------------------------------------------------------
// audio_bit_crusher_unit_checker
// Port-level checks for the bit crusher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_bit_crusher_unit_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   cfg_ready,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [SAMPLE_BITS-1:0] m_sample_out
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out))
        else $error("stalled result changed or dropped");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid || m_ready)
        else $error("input taken while result register is occupied");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 !m_valid |-> !s_ready)
        else $error("second input taken while a sample is computing");

    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind audio_bit_crusher_unit audio_bit_crusher_unit_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_ready    (cfg_ready),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);

`default_nettype wire

FILE: tb/audio_bit_crusher_unit_test.sv
// ----------------------------------------------------------------------------
// audio_bit_crusher_unit_test
// Self-checking test of the bit crusher: directed corner samples under fixed
// gain, depth and hold settings, then random phases that change every register,
// most with both handshakes stalling in random bursts. A scoreboard predicts each
// crushed or held sample and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module audio_bit_crusher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SAMPLE_W      = 24;
    localparam int  GAIN_FRAC     = 16;
    localparam int  RANDOM_ITEMS  = 700;
    localparam int  QUIET_ITEMS   = 100;
    localparam int  CYCLE_LIMIT   = 300000;
    localparam int  LONG_HOLD_OFF = 400;
    localparam abc_pkg::gain_t UNITY_GAIN = 24'h010000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [abc_pkg::GAIN_BITS-1:0] word_t;

    class sample_scoreboard;
        abc_pkg::gain_t  drive_gain;
        abc_pkg::depth_t depth_bits;
        abc_pkg::hold_t  hold_factor;
        abc_pkg::gain_t  out_gain;
        abc_pkg::hold_t  hold_count;
        sample_t         held_sample;
        sample_t         expected_samples[$];
        int              errors;

        function new();
            drive_gain  = UNITY_GAIN;
            depth_bits  = abc_pkg::depth_t'(abc_pkg::DEPTH_MAX);
            hold_factor = '0;
            out_gain    = UNITY_GAIN;
            hold_count  = '0;
            held_sample = '0;
            errors      = 0;
        endfunction

        function void set_reg(abc_pkg::cfg_index_t idx, word_t data);
            case (idx)
                abc_pkg::CFG_DRIVE_GAIN:  drive_gain  = data;
                abc_pkg::CFG_DEPTH_BITS:  depth_bits  = data[abc_pkg::DEPTH_W-1:0];
                abc_pkg::CFG_HOLD_FACTOR: hold_factor = data[abc_pkg::HOLD_W-1:0];
                abc_pkg::CFG_OUT_GAIN:    out_gain    = data;
                default: ;
            endcase
        endfunction

        function longint apply_gain(longint x, abc_pkg::gain_t g);
            longint p;
            longint fs_max;
            fs_max = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
            p = (x * longint'({1'b0, g})) >>> GAIN_FRAC;
            if (p > fs_max) return fs_max;
            if (p < -fs_max - 1) return -fs_max - 1;
            return p;
        endfunction

        function sample_t crush_sample(sample_t x);
            int     b;
            int     k;
            longint v;
            b = int'(depth_bits);
            if (b < 1) b = 1;
            if (b > abc_pkg::DEPTH_MAX) b = abc_pkg::DEPTH_MAX;
            k = SAMPLE_W - b;
            v = apply_gain(longint'(x), drive_gain);
            v = (v >>> k) <<< k;
            return sample_t'(apply_gain(v, out_gain));
        endfunction

        function void note_sample(sample_t x);
            hold_count = hold_count + 1'b1;
            if (hold_count >= hold_factor) begin
                hold_count  = '0;
                held_sample = crush_sample(x);
            end
            expected_samples.push_back(held_sample);
        endfunction

        function void check_result(sample_t got);
            sample_t want;
            if (expected_samples.size() == 0) begin
                $error("sample_out transfer with nothing expected: got %0d", got);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    $error("sample_out mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [abc_pkg::CFG_INDEX_W-1:0]   cfg_index;
    word_t                             cfg_data;
    logic                              s_valid;
    logic                              s_ready;
    sample_t                           s_sample_in;
    logic                              m_valid;
    logic                              m_ready;
    sample_t                           m_sample_out;

    sample_scoreboard sb;
    bit               bursts_on;
    int               long_stall;
    int               rx_gap;
    int               cycles;

    audio_bit_crusher_unit #(
        .SAMPLE_BITS    (SAMPLE_W),
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        rx_gap = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_sample_out);
            if (long_stall > 0) begin
                long_stall--;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(abc_pkg::cfg_index_t idx, word_t data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, data);
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic configure(abc_pkg::gain_t drive, word_t depth_word,
                             word_t hold_word, abc_pkg::gain_t outg);
        write_reg(abc_pkg::CFG_DRIVE_GAIN, drive, 1'b0);
        write_reg(abc_pkg::CFG_DEPTH_BITS, depth_word, 1'b0);
        write_reg(abc_pkg::CFG_HOLD_FACTOR, hold_word, 1'b0);
        write_reg(abc_pkg::CFG_OUT_GAIN, outg, 1'b1);
    endtask

    // hold valid high across back-to-back transfers; lowering is left to the callers
    task automatic send_sample(sample_t x);
        s_valid     <= 1'b1;
        s_sample_in <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(x);
    endtask

    task automatic sender_idle(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic abc_pkg::gain_t pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return UNITY_GAIN;
            3:       return abc_pkg::gain_t'($urandom_range(0, 32'h030000));
            default: return abc_pkg::gain_t'($urandom());
        endcase
    endfunction

    function automatic sample_t pick_sample();
        sample_t s;
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            2: begin
                s = sample_t'($urandom_range(0, 511));
                if ($urandom_range(0, 1) == 1) s = -s;
                return s;
            end
            default: return sample_t'($urandom());
        endcase
    endfunction

    initial begin
        word_t depth_word;
        word_t hold_word;
        int    sent;
        int    phase;
        int    n;

        sb = new();
        bursts_on   = 1'b0;
        long_stall  = 0;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= abc_pkg::CFG_DRIVE_GAIN;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_sample_in <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(24'sd0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        drain();

        configure('1, 24'd0, 24'd0, UNITY_GAIN);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample(24'sd3);
        send_sample(-24'sd3);
        drain();

        configure('0, 24'd31, 24'd0, '1);
        send_sample(24'sd1234567);
        send_sample(-24'sd7654321);
        drain();
        configure(UNITY_GAIN, 24'd17, 24'd0, '0);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        drain();

        configure(24'h018000, 24'd7, 24'd5, 24'h00C000);
        repeat (6) send_sample(pick_sample());
        repeat (3) send_sample(pick_sample());
        drain();
        write_reg(abc_pkg::CFG_HOLD_FACTOR, 24'd2, 1'b1);
        send_sample(24'sd4000000);
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            depth_word = word_t'($urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0) depth_word |= word_t'($urandom() & 32'hFFFFE0);
            case ($urandom_range(0, 9))
                0:       hold_word = 24'd255;
                1:       hold_word = 24'd0;
                2:       hold_word = 24'd1;
                default: hold_word = word_t'($urandom_range(2, 8));
            endcase
            if (phase == 0) hold_word = 24'd255;
            if ($urandom_range(0, 3) == 0) hold_word |= word_t'($urandom() & 32'hFFFF00);
            configure(pick_gain(), depth_word, hold_word, pick_gain());

            if (sent < RANDOM_ITEMS - QUIET_ITEMS) bursts_on = ($urandom_range(0, 3) != 0);
            else bursts_on = 1'b0;
            if (phase == 1) long_stall = LONG_HOLD_OFF;

            n = $urandom_range(30, 90);
            if (sent < RANDOM_ITEMS - QUIET_ITEMS && sent + n > RANDOM_ITEMS - QUIET_ITEMS)
                n = RANDOM_ITEMS - QUIET_ITEMS - sent;
            if (sent + n > RANDOM_ITEMS) n = RANDOM_ITEMS - sent;
            repeat (n) begin
                if (bursts_on && $urandom_range(0, 5) == 0) sender_idle($urandom_range(1, 14));
                send_sample(pick_sample());
            end
            sent += n;
            phase++;
            drain();
        end

        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
